// ----- hw/rtl/button_click_hold_detector_top_assert.svh -----
// Assertion macros for the button click/hold detector checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef BUTTON_CLICK_HOLD_DETECTOR_TOP_ASSERT_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_TOP_ASSERT_SVH

// Clocked property checked outside reset.
`define BCHD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication from a trigger to a consequent in the same cycle.
`define BCHD_ASSERT_IMPL(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/bchd_pkg.sv -----
// Shared types and constants of the button click/hold detector.
// No dependencies; imported by the top level and its checker.
package bchd_pkg;

	localparam int IDX_W      = 3;
	localparam int TIME_W     = 32;
	localparam int OUT_CNT_W  = 16;
	localparam int BUIU_W     = 4;
	localparam int MS_W       = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic CMD_SCAN = 1'b0;
	localparam logic CMD_INIT = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BUTTONS_IN_USE      = 3'd0,
		CFG_DEBOUNCE_MS         = 3'd1,
		CFG_CLICK_MAX_MS        = 3'd2,
		CFG_HOLD_MS             = 3'd3,
		CFG_DOUBLE_CLICK_GAP_MS = 3'd4
	} cfg_reg_t;

	localparam logic [BUIU_W-1:0] RST_BUTTONS_IN_USE      = 4'd8;
	localparam logic [MS_W-1:0]   RST_DEBOUNCE_MS         = 16'd20;
	localparam logic [MS_W-1:0]   RST_CLICK_MAX_MS        = 16'd400;
	localparam logic [MS_W-1:0]   RST_HOLD_MS             = 16'd1000;
	localparam logic [MS_W-1:0]   RST_DOUBLE_CLICK_GAP_MS = 16'd300;

	typedef struct packed {
		logic              cmd;
		logic [IDX_W-1:0]  button_index;
		logic              raw_pressed;
		logic [TIME_W-1:0] now_ms;
	} scan_item_t;

	typedef struct packed {
		logic                 ignored;
		logic                 pressed;
		logic                 held;
		logic [OUT_CNT_W-1:0] single_total;
		logic [OUT_CNT_W-1:0] double_total;
		logic [OUT_CNT_W-1:0] hold_total;
	} result_item_t;

endpackage

// ----- hw/rtl/button_click_hold_detector_top.sv -----
// Button debounce and click / double-click / hold detector, top level.
// Depends on bchd_pkg for the item types and register codes.
//
// Usage:
// Each scan item names a button, its raw level and a millisecond timestamp;
// the block answers every item with exactly one result item, in order.
// A scan item debounces the level and updates the click, double-click and
// hold counters of that button; an init item reloads the button from its
// raw level and clears it. Items for buttons at or above buttons_in_use
// (scans) or beyond the store (any item) come back with ignored set.
// An accepted item is registered into the compute stage, and its result
// into the result register that offers it. One item is accepted every cycle
// while the result side does not stall: the per-button records sit in a
// memory with a registered read, and a record written in one cycle is
// forwarded to an item for the same button that was read in that cycle.
// Throughput is set by that single read-modify-write of one record. Reset
// clears all records through per-entry valid bits and loads the register
// defaults; no clearing pass is needed. While the result side stalls, the
// finished result is held and a waiting compute item raises scan_stall.
module button_click_hold_detector_top
	import bchd_pkg::*;
#(
	parameter int NUM_BUTTONS = 8,
	parameter int COUNT_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  scan_valid,
	output logic                  scan_stall,
	input  scan_item_t            scan,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_item_t          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	typedef struct packed {
		logic                  raw_level;
		logic [TIME_W-1:0]     raw_change_time;
		logic                  debounced_level;
		logic                  held_flag;
		logic [COUNT_BITS-1:0] clicks;
		logic [COUNT_BITS-1:0] double_clicks;
		logic [COUNT_BITS-1:0] holds;
		logic [TIME_W-1:0]     press_start_time;
		logic                  hold_done;
		logic                  awaiting_second;
		logic [TIME_W-1:0]     pending_click_time;
	} btn_rec_t;

	// Configuration registers.
	logic [BUIU_W-1:0] buttons_in_use_q;
	logic [MS_W-1:0]   debounce_ms_q;
	logic [MS_W-1:0]   click_max_ms_q;
	logic [MS_W-1:0]   hold_ms_q;
	logic [MS_W-1:0]   gap_ms_q;

	btn_rec_t mem [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] vld_q;

	logic         scan_acc;
	logic [AW-1:0] rd_addr;

	logic         valid_s1;
	scan_item_t   item_s1;
	btn_rec_t     rd_rec_s1;
	logic         rd_vld_s1;
	logic         fwd_s1;
	btn_rec_t     wr_rec_q;

	logic         adv_s1;
	logic [AW-1:0] addr_s1;
	logic         apply_s1;
	btn_rec_t     cur_rec;
	btn_rec_t     nxt_rec;
	result_item_t res_s1;

	logic         res_valid_q;
	result_item_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buttons_in_use_q <= RST_BUTTONS_IN_USE;
			debounce_ms_q    <= RST_DEBOUNCE_MS;
			click_max_ms_q   <= RST_CLICK_MAX_MS;
			hold_ms_q        <= RST_HOLD_MS;
			gap_ms_q         <= RST_DOUBLE_CLICK_GAP_MS;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_BUTTONS_IN_USE:      buttons_in_use_q <= cfg_data[BUIU_W-1:0];
				CFG_DEBOUNCE_MS:         debounce_ms_q    <= cfg_data[MS_W-1:0];
				CFG_CLICK_MAX_MS:        click_max_ms_q   <= cfg_data[MS_W-1:0];
				CFG_HOLD_MS:             hold_ms_q        <= cfg_data[MS_W-1:0];
				CFG_DOUBLE_CLICK_GAP_MS: gap_ms_q         <= cfg_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the compute stage moves on when the result register is free
	// or being emptied; a new item enters only when the stage is empty or empties.
	assign adv_s1     = valid_s1 && (!res_valid_q || !result_stall);
	assign scan_stall = valid_s1 && !adv_s1;
	assign scan_acc   = scan_valid && !scan_stall;
	assign rd_addr    = AW'(scan.button_index);
	assign addr_s1    = AW'(item_s1.button_index);

	always_comb begin
		logic              in_store;
		logic              in_use;
		logic              prev;
		logic              rise;
		logic              fall;
		logic [TIME_W-1:0] d_raw;
		logic [TIME_W-1:0] d_press;
		logic [TIME_W-1:0] d_pend;
		btn_rec_t          r;

		prev    = 1'b0;
		rise    = 1'b0;
		fall    = 1'b0;
		d_raw   = '0;
		d_press = '0;
		d_pend  = '0;

		in_store = 32'(item_s1.button_index) < 32'(NUM_BUTTONS);
		in_use   = {1'b0, item_s1.button_index} < buttons_in_use_q;
		apply_s1 = in_store && ((item_s1.cmd == CMD_INIT) || in_use);

		cur_rec = fwd_s1 ? wr_rec_q : (rd_vld_s1 ? rd_rec_s1 : '0);
		r = cur_rec;

		if (item_s1.cmd == CMD_INIT) begin
			r = '0;
			r.raw_level       = item_s1.raw_pressed;
			r.raw_change_time = item_s1.now_ms;
			r.debounced_level = item_s1.raw_pressed;
		end else begin
			if (item_s1.raw_pressed != r.raw_level) begin
				r.raw_level       = item_s1.raw_pressed;
				r.raw_change_time = item_s1.now_ms;
			end
			prev  = r.debounced_level;
			d_raw = item_s1.now_ms - r.raw_change_time;
			if (r.raw_level != r.debounced_level && d_raw >= TIME_W'(debounce_ms_q))
				r.debounced_level = r.raw_level;
			rise = r.debounced_level && !prev;
			fall = !r.debounced_level && prev;

			if (rise) begin
				r.press_start_time = item_s1.now_ms;
				r.hold_done        = 1'b0;
			end
			d_press = item_s1.now_ms - r.press_start_time;
			if (fall) begin
				r.held_flag = 1'b0;
				if (!r.hold_done && d_press <= TIME_W'(click_max_ms_q)) begin
					if (r.awaiting_second) begin
						r.double_clicks   = r.double_clicks + COUNT_BITS'(1);
						r.awaiting_second = 1'b0;
					end else begin
						r.awaiting_second    = 1'b1;
						r.pending_click_time = item_s1.now_ms;
					end
				end
			end
			if (r.debounced_level && !r.hold_done && d_press >= TIME_W'(hold_ms_q)) begin
				r.held_flag       = 1'b1;
				r.holds           = r.holds + COUNT_BITS'(1);
				r.hold_done       = 1'b1;
				r.awaiting_second = 1'b0;
			end
			d_pend = item_s1.now_ms - r.pending_click_time;
			if (r.awaiting_second && !r.debounced_level && d_pend >= TIME_W'(gap_ms_q)) begin
				r.clicks          = r.clicks + COUNT_BITS'(1);
				r.awaiting_second = 1'b0;
			end
		end
		nxt_rec = r;

		if (apply_s1) begin
			res_s1.ignored      = 1'b0;
			res_s1.pressed      = r.debounced_level;
			res_s1.held         = r.held_flag;
			res_s1.single_total = OUT_CNT_W'(r.clicks);
			res_s1.double_total = OUT_CNT_W'(r.double_clicks);
			res_s1.hold_total   = OUT_CNT_W'(r.holds);
		end else begin
			res_s1         = '0;
			res_s1.ignored = 1'b1;
		end
	end

	// Record memory: registered read on acceptance, write-back of an applied
	// item as it leaves the compute stage.
	always_ff @(posedge clk) begin
		if (scan_acc)
			rd_rec_s1 <= mem[rd_addr];
		if (adv_s1 && apply_s1)
			mem[addr_s1] <= nxt_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv_s1 && apply_s1) begin
			vld_q[addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (scan_acc)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
		end
	end

	// The write that lands on the edge of a read is not seen by that read,
	// so its record is kept and forwarded to the next item if it matches.
	always_ff @(posedge clk) begin
		if (scan_acc) begin
			item_s1   <= scan;
			rd_vld_s1 <= vld_q[rd_addr];
			fwd_s1    <= adv_s1 && apply_s1 && (addr_s1 == rd_addr);
		end
		if (adv_s1) begin
			wr_rec_q <= nxt_rec;
			res_q    <= res_s1;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ----- hw/rtl/bchd_checker.sv -----
// Port-level checker for the button click/hold detector, bound to the top.
// Depends on bchd_pkg and the assertion macro header.
`include "button_click_hold_detector_top_assert.svh"

module bchd_checker
	import bchd_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         result_valid,
	input logic         result_stall,
	input result_item_t result
);

	`BCHD_ASSERT(a_res_valid_holds, result_valid && result_stall |=> result_valid, "result item dropped while stalled")
	`BCHD_ASSERT(a_res_stable, result_valid && result_stall |=> $stable(result), "stalled result item changed")
	`BCHD_ASSERT_IMPL(a_ignored_zero, result_valid && result.ignored, !result.pressed && !result.held && result.single_total == '0 && result.double_total == '0 && result.hold_total == '0, "ignored item carries state")
	`BCHD_ASSERT_IMPL(a_held_pressed, result_valid && result.held, result.pressed, "hold reported on a released button")

endmodule

bind button_click_hold_detector_top bchd_checker u_bchd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
